[src/dwpi_pkg.sv]
// ----------------------------------------------------------------------------
// dwpi_pkg
// Shared types and constants for the dual-wheel PI velocity controller.
// ----------------------------------------------------------------------------
package dwpi_pkg;

    localparam int INTEGRATOR_WIDTH_DEF = 24;

    localparam logic [21:0] LIMIT_RESET = 22'd335544;
    localparam int          DRIVE_LIMIT = 400;

    // shared multiplier: signed MUL_A_W x signed MUL_B_W
    localparam int MUL_A_W     = 25;
    localparam int MUL_B_W     = 21;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    // integrator split for the I product: low SPLIT bits, then a signed high part
    localparam int SPLIT       = MUL_B_W - 1;
    localparam int EXT_W       = SPLIT + MUL_B_W;
    localparam int ACC_W       = 66;
    localparam int INC_SHIFT   = 4;
    localparam int P_SHIFT     = 12;
    localparam int DRIVE_SHIFT = 36;
    localparam int DRIVE_RAW_W = ACC_W - DRIVE_SHIFT;

    localparam logic [1:0] KIND_RIGHT = 2'd0;
    localparam logic [1:0] KIND_LEFT  = 2'd1;
    localparam logic [1:0] MOTOR_BOTH = 2'd2;

    localparam logic [2:0] REG_RIGHT_KP = 3'd0;
    localparam logic [2:0] REG_RIGHT_KI = 3'd1;
    localparam logic [2:0] REG_LEFT_KP  = 3'd2;
    localparam logic [2:0] REG_LEFT_KI  = 3'd3;
    localparam logic [2:0] REG_PERIOD   = 3'd4;
    localparam logic [2:0] REG_LIMIT    = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INC,
        ST_INTEG,
        ST_ILO,
        ST_IHI,
        ST_SUM,
        ST_DONE
    } state_t;

endpackage

[src/dual_wheel_pi_velocity_control.sv]
// ----------------------------------------------------------------------------
// dual_wheel_pi_velocity_control
// Two-wheel PI velocity controller with clamped integrators.
// ----------------------------------------------------------------------------
// Input stream: one beat per control sample. s_axis_tuser selects the wheel
// (right, left, or invalid), s_axis_tdata carries desired and measured speed.
// Output stream: exactly one beat per input beat, in order, holding the
// motor select, the saturated drive and the clamp flag.
// Gains, sample period and integrator limit sit behind the APB port; write
// them only while the block is idle.
// A wheel sample steps through INC, INTEG, ILO, IHI and SUM to DONE and
// the result register; an invalid sample goes straight to DONE. One 25x21
// multiplier is reused for the integrator increment, the P term and the
// two halves of the I term, under a small sequencer; s_axis_tready is
// high only in idle. A finished result waits in the output register while
// the next beat is taken; if the receiver stalls, the sequencer holds its
// last step until the output register frees up.
// Reset clears both integrators, the gains and sample period to zero and
// the integrator limit to about 0.02.
// ----------------------------------------------------------------------------
module dual_wheel_pi_velocity_control #(
    parameter int INTEGRATOR_WIDTH = dwpi_pkg::INTEGRATOR_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] desired_velocity, [31:16] measured_velocity
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [9:0] drive, [10] drive_clamped, [15:11] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] motor_select

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dwpi_pkg::*;

    localparam int IW    = INTEGRATOR_WIDTH;
    localparam int SUM_W = ((IW > PROD_W - INC_SHIFT) ? IW : (PROD_W - INC_SHIFT)) + 1;
    localparam logic [SUM_W-1:0] WMAX = (SUM_W'(1) << (IW - 1)) - SUM_W'(1);

    logic [23:0] right_kp_reg, right_ki_reg, left_kp_reg, left_ki_reg;
    logic [15:0] period_reg;
    logic [21:0] limit_reg;

    logic signed [IW-1:0]     right_integ_reg, left_integ_reg;
    logic signed [IW-1:0]     integ_reg;
    state_t                   state_reg, state_next;
    logic [1:0]               kind_reg;
    logic signed [16:0]       err_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    logic        out_valid_reg;
    logic [1:0]  out_sel_reg;
    logic [9:0]  out_drive_reg;
    logic        out_clamp_reg;

    logic cfg_wr;
    logic accept;
    logic out_free;
    logic load_out;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    logic signed [16:0]      err_in;
    logic signed [IW-1:0]    cur_integ;
    logic [23:0]             gain_p, gain_i;
    logic signed [EXT_W-1:0] integ_ext;
    logic signed [SUM_W-1:0] inc_s, sum_s, lim_s;
    logic [SUM_W-1:0]        lim_u;
    logic signed [IW-1:0]    integ_new;

    logic signed [DRIVE_RAW_W-1:0] drive_raw;
    logic signed [DRIVE_RAW_W:0]   drive_sgn;
    logic [1:0]                    res_sel;
    logic [9:0]                    res_drive;
    logic                          res_clamp;

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[4:2])
            REG_RIGHT_KP: prdata = {8'd0, right_kp_reg};
            REG_RIGHT_KI: prdata = {8'd0, right_ki_reg};
            REG_LEFT_KP:  prdata = {8'd0, left_kp_reg};
            REG_LEFT_KI:  prdata = {8'd0, left_ki_reg};
            REG_PERIOD:   prdata = {16'd0, period_reg};
            REG_LIMIT:    prdata = {10'd0, limit_reg};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_kp_reg <= '0;
            right_ki_reg <= '0;
            left_kp_reg  <= '0;
            left_ki_reg  <= '0;
            period_reg   <= '0;
            limit_reg    <= LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_RIGHT_KP: right_kp_reg <= pwdata[23:0];
                REG_RIGHT_KI: right_ki_reg <= pwdata[23:0];
                REG_LEFT_KP:  left_kp_reg  <= pwdata[23:0];
                REG_LEFT_KI:  left_ki_reg  <= pwdata[23:0];
                REG_PERIOD:   period_reg   <= pwdata[15:0];
                REG_LIMIT:    limit_reg    <= pwdata[21:0];
                default:      ;
            endcase
        end
    end

    // datapath
    assign err_in = {s_axis_tdata[15], s_axis_tdata[15:0]}
                  - {s_axis_tdata[31], s_axis_tdata[31:16]};

    assign cur_integ = kind_reg[0] ? left_integ_reg : right_integ_reg;
    assign gain_p    = kind_reg[0] ? left_kp_reg : right_kp_reg;
    assign gain_i    = kind_reg[0] ? left_ki_reg : right_ki_reg;
    assign integ_ext = EXT_W'(integ_reg);

    assign mul_p = mul_a * mul_b;

    assign inc_s = SUM_W'(prod_reg >>> INC_SHIFT);
    assign sum_s = SUM_W'(cur_integ) + inc_s;
    assign lim_u = (SUM_W'(limit_reg) > WMAX) ? WMAX : SUM_W'(limit_reg);
    assign lim_s = $signed(lim_u);

    always_comb
    begin
        if (sum_s > lim_s)
            integ_new = IW'(lim_s);
        else if (sum_s < -lim_s)
            integ_new = IW'(-lim_s);
        else
            integ_new = IW'(sum_s);
    end

    always_comb
    begin
        case (state_reg)
            ST_ILO:  acc_next = ACC_W'(prod_reg) <<< P_SHIFT;
            ST_IHI:  acc_next = acc_reg + ACC_W'(prod_reg);
            ST_SUM:  acc_next = acc_reg + (ACC_W'(prod_reg) <<< SPLIT);
            default: acc_next = acc_reg;
        endcase
    end

    // final drive: floor shift, left sign flip, saturation
    assign drive_raw = acc_reg[ACC_W-1:DRIVE_SHIFT];

    always_comb
    begin
        drive_sgn = (kind_reg == KIND_LEFT) ? -(DRIVE_RAW_W+1)'(drive_raw)
                                            : (DRIVE_RAW_W+1)'(drive_raw);
        if (kind_reg != KIND_RIGHT && kind_reg != KIND_LEFT)
        begin
            res_sel   = MOTOR_BOTH;
            res_drive = '0;
            res_clamp = 1'b0;
        end
        else if (drive_sgn > (DRIVE_RAW_W+1)'(DRIVE_LIMIT))
        begin
            res_sel   = kind_reg;
            res_drive = 10'(DRIVE_LIMIT);
            res_clamp = 1'b1;
        end
        else if (drive_sgn < -(DRIVE_RAW_W+1)'(DRIVE_LIMIT))
        begin
            res_sel   = kind_reg;
            res_drive = 10'(-DRIVE_LIMIT);
            res_clamp = 1'b1;
        end
        else
        begin
            res_sel   = kind_reg;
            res_drive = drive_sgn[9:0];
            res_clamp = 1'b0;
        end
    end

    // sequencer
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == KIND_RIGHT || s_axis_tuser == KIND_LEFT)
                        state_next = ST_INC;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_INC:   state_next = ST_INTEG;
            ST_INTEG: state_next = ST_ILO;
            ST_ILO:   state_next = ST_IHI;
            ST_IHI:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_INC:
            begin
                mul_a = MUL_A_W'(period_reg);
                mul_b = MUL_B_W'(err_reg);
            end
            ST_INTEG:
            begin
                mul_a = MUL_A_W'(gain_p);
                mul_b = MUL_B_W'(err_reg);
            end
            ST_ILO:
            begin
                mul_a = MUL_A_W'(gain_i);
                mul_b = MUL_B_W'(integ_ext[SPLIT-1:0]);
            end
            ST_IHI:
            begin
                mul_a = MUL_A_W'(gain_i);
                mul_b = integ_ext[EXT_W-1:SPLIT];
            end
            ST_DONE:
            begin
                load_out = out_free;
            end
            default: ;
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            right_integ_reg <= '0;
            left_integ_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_INTEG)
            begin
                if (kind_reg[0])
                    left_integ_reg <= integ_new;
                else
                    right_integ_reg <= integ_new;
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= s_axis_tuser;
            err_reg  <= err_in;
        end
        if (state_reg == ST_INTEG)
            integ_reg <= integ_new;
        prod_reg <= mul_p;
        acc_reg  <= acc_next;
        if (load_out)
        begin
            out_sel_reg   <= res_sel;
            out_drive_reg <= res_drive;
            out_clamp_reg <= res_clamp;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_sel_reg;
    assign m_axis_tdata  = {5'd0, out_clamp_reg, out_drive_reg};

endmodule
